// ===== src/mscf_pkg.sv =====
// Shared types, constants and helpers of the meter command framer.
// No dependencies; every module of the block imports this package.
`default_nettype none
package mscf_pkg;

  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned S_TUSER_W = 3;
  localparam int unsigned M_TDATA_W = 40;
  localparam int unsigned M_TUSER_W = 1;

  localparam int unsigned MAX_BYTES = 6;
  localparam int unsigned IDX_W     = $clog2(MAX_BYTES);
  localparam int unsigned NB_W      = $clog2(MAX_BYTES + 1);

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned PTR_W   = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned CNT_W   = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] OP_WRITE  = 8'h40;
  localparam logic [7:0] OP_PAGE   = 8'h80;
  localparam logic [7:0] OP_INSTR  = 8'hC0;
  localparam logic [7:0] BYTE_FILL = 8'hFF;
  localparam logic [7:0] BYTE_ZERO = 8'h00;

  localparam logic [1:0] RX_DATA_LAST = 2'd2;

  localparam logic KIND_TX   = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  typedef enum logic [2:0] {
    CMD_WRITE = 3'd0,
    CMD_READ  = 3'd1,
    CMD_PAGE  = 3'd2,
    CMD_INSTR = 3'd3,
    CMD_RX    = 3'd4
  } cmd_e;

  typedef struct packed {
    logic                            kind;
    logic [NB_W-1:0]                 nbytes;
    logic [MAX_BYTES-1:0][7:0]       bytes;
    logic [23:0]                     value;
    logic                            status;
  } desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [7:0] sum3(input logic [23:0] v);
    sum3 = v[23:16] + v[15:8] + v[7:0];
  endfunction

endpackage
`default_nettype wire

// ===== src/mscf_front.sv =====
// Front end: accepts requests and received bytes, tracks the pending read
// and builds a frame descriptor per request and a completion descriptor per finished read. Uses mscf_pkg.
`default_nettype none
module mscf_front (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire                            cfg_wdata_i,
  input  wire                            s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // target[5:0], write_data[29:6], rx_byte[37:30], zero pad
  input  wire  [mscf_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  // command[2:0]
  input  wire  [mscf_pkg::S_TUSER_W-1:0] s_axis_tuser_i,
  input  mscf_pkg::q_stat_t              stat_i,
  output logic                           push_o,
  output mscf_pkg::desc_t                desc_o
);
  import mscf_pkg::*;

  logic        cs_q;
  logic        pend_q, pend_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [23:0] acc_q, acc_d;
  logic        emit;
  logic        s_xfer;
  cmd_e        cmd;
  logic [7:0]  tgt8;
  logic [23:0] data;
  logic [7:0]  rx;
  logic [23:0] shifted;

  assign cmd     = cmd_e'(s_axis_tuser_i);
  assign tgt8    = {2'b00, s_axis_tdata_i[5:0]};
  assign data    = s_axis_tdata_i[29:6];
  assign rx      = s_axis_tdata_i[37:30];
  assign shifted = {acc_q[15:0], rx};

  assign s_axis_tready_o = !stat_i.full;
  assign s_xfer          = s_axis_tvalid_i && s_axis_tready_o;
  assign push_o          = s_xfer && emit;

  always_comb begin
    desc_o = '0;
    emit   = 1'b0;
    pend_d = pend_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    unique case (cmd)
      CMD_WRITE: begin
        pend_d          = 1'b0;
        cnt_d           = '0;
        acc_d           = '0;
        emit            = 1'b1;
        desc_o.kind     = KIND_TX;
        desc_o.bytes[0] = OP_WRITE | tgt8;
        desc_o.bytes[1] = data[23:16];
        desc_o.bytes[2] = data[15:8];
        desc_o.bytes[3] = data[7:0];
        desc_o.bytes[4] = ~sum3(data);
        desc_o.nbytes   = cs_q ? NB_W'(5) : NB_W'(4);
      end
      CMD_READ: begin
        pend_d          = 1'b1;
        cnt_d           = '0;
        acc_d           = '0;
        emit            = 1'b1;
        desc_o.kind     = KIND_TX;
        desc_o.bytes    = {MAX_BYTES{BYTE_FILL}};
        desc_o.bytes[0] = tgt8;
        if (cs_q) begin
          desc_o.bytes[1] = ~tgt8;
          desc_o.nbytes   = NB_W'(6);
        end else begin
          desc_o.nbytes   = NB_W'(4);
        end
      end
      CMD_PAGE, CMD_INSTR: begin
        pend_d          = 1'b0;
        cnt_d           = '0;
        acc_d           = '0;
        emit            = 1'b1;
        desc_o.kind     = KIND_TX;
        desc_o.bytes[0] = ((cmd == CMD_PAGE) ? OP_PAGE : OP_INSTR) | tgt8;
        desc_o.bytes[1] = ~tgt8;
        desc_o.nbytes   = cs_q ? NB_W'(2) : NB_W'(1);
      end
      CMD_RX: begin
        if (pend_q) begin
          if (cnt_q <= RX_DATA_LAST) begin
            acc_d = shifted;
            cnt_d = cnt_q + 2'd1;
            if (cnt_q == RX_DATA_LAST && !cs_q) begin
              emit          = 1'b1;
              desc_o.kind   = KIND_DONE;
              desc_o.nbytes = NB_W'(1);
              desc_o.value  = shifted;
              desc_o.status = 1'b0;
              pend_d        = 1'b0;
              cnt_d         = '0;
            end
          end else begin
            emit          = 1'b1;
            desc_o.kind   = KIND_DONE;
            desc_o.nbytes = NB_W'(1);
            desc_o.value  = acc_q;
            desc_o.status = cs_q && (rx != ~sum3(acc_q));
            pend_d        = 1'b0;
            cnt_d         = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs_q   <= 1'b0;
      pend_q <= 1'b0;
      cnt_q  <= '0;
      acc_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        cs_q <= cfg_wdata_i;
      end
      if (s_xfer) begin
        pend_q <= pend_d;
        cnt_q  <= cnt_d;
        acc_q  <= acc_d;
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/mscf_fifo.sv =====
// Short descriptor queue between the front end and the byte serialiser.
// Uses mscf_pkg for the descriptor type and depth.
`default_nettype none
module mscf_fifo (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                push_i,
  input  mscf_pkg::desc_t    desc_i,
  input  wire                pop_i,
  output mscf_pkg::desc_t    head_o,
  output mscf_pkg::q_stat_t  stat_o
);
  import mscf_pkg::*;

  desc_t             mem_q [Q_DEPTH];
  logic [PTR_W-1:0]  wr_q, rd_q;
  logic [CNT_W-1:0]  count_q;

  assign head_o       = mem_q[rd_q];
  assign stat_o.full  = (count_q == CNT_W'(Q_DEPTH));
  assign stat_o.empty = (count_q == '0);

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    ptr_next = (p == PTR_W'(Q_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= ptr_next(wr_q);
      end
      if (pop_i) begin
        rd_q <= ptr_next(rd_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

`ifndef SYNTH
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !stat_o.full) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !stat_o.empty) else $error("pop from empty queue");
  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("queue count did not advance on push");
`endif

endmodule
`default_nettype wire

// ===== src/mscf_back.sv =====
// Back end: serialises the queue head into output transfers, one byte or
// one read completion per transfer. Uses mscf_pkg.
`default_nettype none
module mscf_back (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  mscf_pkg::desc_t                head_i,
  input  mscf_pkg::q_stat_t              stat_i,
  output logic                           pop_o,
  output logic                           m_axis_tvalid_o,
  input  wire                            m_axis_tready_i,
  // tx_byte[7:0], read_value[31:8], status[32], zero pad
  output logic [mscf_pkg::M_TDATA_W-1:0] m_axis_tdata_o,
  // kind[0]
  output logic [mscf_pkg::M_TUSER_W-1:0] m_axis_tuser_o,
  output logic                           m_axis_tlast_o
);
  import mscf_pkg::*;

  logic [IDX_W-1:0] idx_q, idx_d;
  logic             last;
  logic             m_xfer;
  logic [7:0]       cur_byte;

  assign m_axis_tvalid_o = !stat_i.empty;
  assign m_xfer          = m_axis_tvalid_o && m_axis_tready_i;
  assign last            = (NB_W'(idx_q) + NB_W'(1) == head_i.nbytes);
  assign pop_o           = m_xfer && last;
  assign cur_byte        = head_i.bytes[idx_q];

  always_comb begin
    m_axis_tuser_o = M_TUSER_W'(head_i.kind);
    if (head_i.kind == KIND_DONE) begin
      m_axis_tdata_o = {7'b0, head_i.status, head_i.value, BYTE_ZERO};
      m_axis_tlast_o = 1'b0;
    end else begin
      m_axis_tdata_o = {8'b0, 24'b0, cur_byte};
      m_axis_tlast_o = last;
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (pop_o) begin
      idx_d = '0;
    end else if (m_xfer) begin
      idx_d = idx_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule
`default_nettype wire

// ===== src/meter_spi_command_framer.sv =====
// Top level of the meter serial command framer: front end, descriptor queue
// and byte serialiser. Uses mscf_pkg, mscf_front, mscf_fifo and mscf_back.
//
// channel    direction  handshake                        payload
// s_axis     in         s_axis_tvalid_i/s_axis_tready_o  tuser command, tdata operands
// m_axis     out        m_axis_tvalid_o/m_axis_tready_i  tuser kind, tdata byte/value
// cfg        in         cfg_we_i                         cfg_wdata_i checksum enable
//
// An input transfer is taken every cycle while the two-entry queue has room.
// The serialiser sends one output transfer a cycle while m_axis_tready_i is high:
// one per frame byte (one to six bytes) and one per read completion.
// Reset clears the queue, the pending read and the checksum enable.
// A stalled output holds its transfer; the front end keeps filling the queue.
`default_nettype none
module meter_spi_command_framer (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire                            cfg_wdata_i,
  input  wire                            s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // target[5:0], write_data[29:6], rx_byte[37:30], zero pad
  input  wire  [mscf_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  // command[2:0]
  input  wire  [mscf_pkg::S_TUSER_W-1:0] s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  wire                            m_axis_tready_i,
  // tx_byte[7:0], read_value[31:8], status[32], zero pad
  output logic [mscf_pkg::M_TDATA_W-1:0] m_axis_tdata_o,
  // kind[0]
  output logic [mscf_pkg::M_TUSER_W-1:0] m_axis_tuser_o,
  output logic                           m_axis_tlast_o
);
  import mscf_pkg::*;

  desc_t   push_desc;
  desc_t   head;
  q_stat_t stat;
  logic    push;
  logic    pop;

  mscf_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .stat_i          (stat),
    .push_o          (push),
    .desc_o          (push_desc)
  );

  mscf_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .desc_i (push_desc),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (stat)
  );

  mscf_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .stat_i          (stat),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the meter serial command framer.
// Depends on mscf_pkg and meter_spi_command_framer; predicts every frame byte
// and read completion and checks them transfer by transfer.
`default_nettype none
module tb;
  import mscf_pkg::*;

  localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
  localparam int HOLD_AT    = 150;
  localparam int HOLD_LEN   = 300;
  localparam int SETTLE_CYC = 12;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [5:0]  tgt;
    logic [23:0] wdata;
    logic [7:0]  rx;
  } req_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  txb;
    logic [23:0] value;
    logic        status;
    logic        eof;
  } out_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_wd = 1'b0;
  logic s_vld = 1'b0;
  logic [S_TDATA_W-1:0] s_data = '0;
  logic [S_TUSER_W-1:0] s_user = '0;
  logic m_rdy = 1'b0;
  wire s_rdy;
  wire m_vld;
  wire [M_TDATA_W-1:0] m_data;
  wire [M_TUSER_W-1:0] m_user;
  wire m_last;

  req_t req_q[$];
  req_t cur;
  out_row_t due_out[$];
  logic req_taken = 1'b0;
  logic out_taken = 1'b0;
  bit idle_on = 1'b1;
  int tx_gap = 0;
  int rx_gap = 0;
  int hold_left = 0;
  int rx_xfers = 0;
  int n_errors = 0;

  logic csum_model = 1'b0;
  logic rd_pend = 1'b0;
  logic [2:0] rx_n = '0;
  logic [23:0] acc = '0;

  always #2 clk = ~clk;

  meter_spi_command_framer DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wd),
    .s_axis_tvalid_i(s_vld),
    .s_axis_tready_o(s_rdy),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .m_axis_tvalid_o(m_vld),
    .m_axis_tready_i(m_rdy),
    .m_axis_tdata_o (m_data),
    .m_axis_tuser_o (m_user),
    .m_axis_tlast_o (m_last)
  );

  function automatic logic [7:0] csum_of(input logic [23:0] v);
    logic [7:0] s;
    s = v[23:16] + v[15:8] + v[7:0];
    return BYTE_FILL - s;
  endfunction

  function automatic req_t mk(input logic [2:0] c, input logic [5:0] t,
                              input logic [23:0] d, input logic [7:0] r);
    req_t q;
    q.cmd = c;
    q.tgt = t;
    q.wdata = d;
    q.rx = r;
    return q;
  endfunction

  task automatic push_tx(input logic [7:0] b, input logic last);
    out_row_t o;
    o = '0;
    o.kind = KIND_TX;
    o.txb = b;
    o.eof = last;
    due_out.push_back(o);
  endtask

  task automatic push_done(input logic [23:0] v, input logic bad);
    out_row_t o;
    o = '0;
    o.kind = KIND_DONE;
    o.value = v;
    o.status = bad;
    due_out.push_back(o);
  endtask

  task automatic frame_request(input req_t r);
    logic cs;
    logic [7:0] t8;
    cs = csum_model;
    t8 = {2'b00, r.tgt};
    if (r.cmd <= CMD_INSTR) begin
      rd_pend = 1'b0;
      rx_n = '0;
      acc = '0;
    end
    case (r.cmd)
      CMD_WRITE: begin
        push_tx(OP_WRITE | t8, 1'b0);
        push_tx(r.wdata[23:16], 1'b0);
        push_tx(r.wdata[15:8], 1'b0);
        push_tx(r.wdata[7:0], !cs);
        if (cs) push_tx(csum_of(r.wdata), 1'b1);
      end
      CMD_READ: begin
        push_tx(t8, 1'b0);
        if (cs) push_tx(BYTE_FILL - t8, 1'b0);
        push_tx(BYTE_FILL, 1'b0);
        push_tx(BYTE_FILL, 1'b0);
        push_tx(BYTE_FILL, !cs);
        if (cs) push_tx(BYTE_FILL, 1'b1);
        rd_pend = 1'b1;
      end
      CMD_PAGE, CMD_INSTR: begin
        push_tx(((r.cmd == CMD_PAGE) ? OP_PAGE : OP_INSTR) | t8, !cs);
        if (cs) push_tx(BYTE_FILL - t8, 1'b1);
      end
      CMD_RX: begin
        if (rd_pend) begin
          if (rx_n < 3) begin
            acc = {acc[15:0], r.rx};
            rx_n = rx_n + 1'b1;
            if (rx_n == 3 && !cs) begin
              push_done(acc, 1'b0);
              rd_pend = 1'b0;
              rx_n = '0;
            end
          end else begin
            push_done(acc, cs && (r.rx != csum_of(acc)));
            rd_pend = 1'b0;
            rx_n = '0;
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("mismatch (%s) at %0t: got %0h, expected %0h", what, $time, got, want);
    n_errors++;
  endtask

  // input side: sample the transfer, advance the model
  always @(posedge clk) begin
    req_taken <= s_vld && s_rdy;
    if (rst_n) begin
      if (cfg_we) csum_model = cfg_wd;
      if (s_vld && s_rdy) frame_request(cur);
    end
  end

  always @(negedge clk) begin : drv
    logic nv;
    if (rst_n) begin
      nv = s_vld;
      if (s_vld && req_taken) begin
        nv = 1'b0;
        tx_gap = idle_on ? $urandom_range(0, 6) : 0;
      end
      if (!nv) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (req_q.size() > 0) begin
          cur = req_q.pop_front();
          s_data <= {2'b00, cur.rx, cur.wdata, cur.tgt};
          s_user <= cur.cmd;
          nv = 1'b1;
        end
      end
      s_vld <= nv;
    end
  end

  // output side: hold off once for a long stretch so the queue backs up
  always @(negedge clk) begin : rcv
    logic rdy;
    if (rst_n) begin
      if (out_taken) begin
        rx_xfers++;
        rx_gap = idle_on ? $urandom_range(0, 6) : 0;
        if (rx_xfers == HOLD_AT) hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      m_rdy <= rdy;
    end
  end

  always @(posedge clk) begin : mon
    out_row_t want;
    out_taken <= m_vld && m_rdy;
    if (rst_n && m_vld && m_rdy) begin
      if (due_out.size() == 0) begin
        flag_mismatch("unexpected transfer", m_data[31:0], '0);
      end else begin
        want = due_out.pop_front();
        if (m_user[0] !== want.kind)
          flag_mismatch("kind", 32'(m_user[0]), 32'(want.kind));
        if (m_data[7:0] !== want.txb)
          flag_mismatch("tx_byte", 32'(m_data[7:0]), 32'(want.txb));
        if (m_data[31:8] !== want.value)
          flag_mismatch("read_value", 32'(m_data[31:8]), 32'(want.value));
        if (m_data[32] !== want.status)
          flag_mismatch("status", 32'(m_data[32]), 32'(want.status));
        if (m_last !== want.eof)
          flag_mismatch("end_of_frame", 32'(m_last), 32'(want.eof));
      end
    end
  end

  task automatic settle();
    while (!(req_q.size() == 0 && !s_vld && due_out.size() == 0)) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_cfg(input logic v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wd <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_random(input int n, input logic cs);
    int k;
    int pick;
    int nb;
    logic [23:0] b;
    logic [7:0] rb;
    k = 0;
    while (k < n) begin
      pick = $urandom_range(0, 19);
      if (pick < 8) begin
        b = 24'($urandom);
        req_q.push_back(mk(CMD_READ, 6'($urandom), 24'($urandom), 8'($urandom)));
        nb = cs ? 4 : 3;
        if ($urandom_range(0, 7) == 0) nb = $urandom_range(1, nb - 1);
        for (int i = 0; i < nb; i++) begin
          if (i < 3) rb = b[23 - 8 * i -: 8];
          else rb = $urandom_range(0, 1) ? csum_of(b) : 8'($urandom);
          req_q.push_back(mk(CMD_RX, 6'($urandom), 24'($urandom), rb));
        end
        k += nb + 1;
      end else if (pick < 16) begin
        req_q.push_back(mk(3'($urandom_range(CMD_WRITE, CMD_INSTR)),
                           6'($urandom), 24'($urandom), 8'($urandom)));
        k++;
      end else if (pick < 18) begin
        req_q.push_back(mk(CMD_RX, 6'($urandom), 24'($urandom), 8'($urandom)));
        k++;
      end else begin
        req_q.push_back(mk(CMD_UNUSED_LO + 3'($urandom_range(0, 2)),
                           6'($urandom), 24'($urandom), 8'($urandom)));
        k++;
      end
    end
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    write_cfg(1'b0);
    req_q.push_back(mk(CMD_WRITE, 6'd0, 24'h000000, 8'h00));
    req_q.push_back(mk(CMD_WRITE, 6'd63, 24'hFFFFFF, 8'hFF));
    req_q.push_back(mk(CMD_READ, 6'd0, 24'h0, 8'h0));
    req_q.push_back(mk(CMD_RX, 6'd0, 24'h0, 8'h00));
    req_q.push_back(mk(CMD_RX, 6'd63, 24'hFFFFFF, 8'hFF));
    req_q.push_back(mk(CMD_RX, 6'd0, 24'h0, 8'hA5));
    req_q.push_back(mk(CMD_RX, 6'd0, 24'h0, 8'h3C));
    req_q.push_back(mk(CMD_PAGE, 6'd0, 24'h0, 8'h0));
    req_q.push_back(mk(CMD_INSTR, 6'd63, 24'h0, 8'h0));
    req_q.push_back(mk(CMD_UNUSED_LO, 6'd1, 24'h1, 8'h1));
    req_q.push_back(mk(CMD_UNUSED_LO + 3'd2, 6'd63, 24'hFFFFFF, 8'hFF));
    req_q.push_back(mk(CMD_READ, 6'd63, 24'h0, 8'h0));
    req_q.push_back(mk(CMD_RX, 6'd0, 24'h0, 8'h12));
    req_q.push_back(mk(CMD_WRITE, 6'd1, 24'hA5A5A5, 8'h0));
    req_q.push_back(mk(CMD_READ, 6'd21, 24'h0, 8'h0));
    settle();

    // read issued without checksum, data arriving with checksum on
    write_cfg(1'b1);
    req_q.push_back(mk(CMD_RX, 6'd0, 24'h0, 8'h11));
    req_q.push_back(mk(CMD_RX, 6'd0, 24'h0, 8'h22));
    req_q.push_back(mk(CMD_RX, 6'd0, 24'h0, 8'h33));
    req_q.push_back(mk(CMD_RX, 6'd0, 24'h0, csum_of(24'h112233)));
    req_q.push_back(mk(CMD_WRITE, 6'h2A, 24'h123456, 8'h0));
    req_q.push_back(mk(CMD_READ, 6'd63, 24'h0, 8'h0));
    req_q.push_back(mk(CMD_RX, 6'd0, 24'h0, 8'hFF));
    req_q.push_back(mk(CMD_RX, 6'd0, 24'h0, 8'hFF));
    req_q.push_back(mk(CMD_RX, 6'd0, 24'h0, 8'hFF));
    req_q.push_back(mk(CMD_RX, 6'd0, 24'h0, 8'h00));
    req_q.push_back(mk(CMD_PAGE, 6'd21, 24'h0, 8'h0));
    settle();

    for (int ph = 0; ph < 4; ph++) begin
      write_cfg(~ph[0]);
      idle_on = (ph != 2);
      queue_random(64, ~ph[0]);
      settle();
    end

    if (n_errors == 0 && due_out.size() == 0) begin
      $display("** meter_spi_command_framer: PASSED **");
    end else begin
      $display("** meter_spi_command_framer: FAILED **");
    end
    $finish;
  end

  initial begin
    #800000;
    $display("** meter_spi_command_framer: FAILED **");
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
src/mscf_pkg.sv
src/mscf_front.sv
src/mscf_fifo.sv
src/mscf_back.sv
src/meter_spi_command_framer.sv
tb/sv/tb.sv
